[design/scfa_pkg.sv]
// scfa_pkg: shared types, constants and the size class table of the allocator
// used by every module of the size class free list allocator, no dependencies
package scfa_pkg;

  localparam int NUM_CLASSES = 13;
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CLS_W       = 4;
  localparam int ADDR_W      = 32;
  localparam int BYTES_W     = 18;
  localparam int ST_W        = 3;
  localparam int MEM_AW      = CLS_W + PTR_W;
  localparam int MEM_DEPTH   = NUM_CLASSES * STACK_DEPTH;
  localparam int HDR_BYTES   = 32;
  localparam int MAX_BYTES   = 128 * 1024;
  localparam int ARENA_RST   = 1048576;
  localparam int CQ_DEPTH    = 2;
  localparam int RQ_DEPTH    = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_ARENA_BASE = 1'b0;
  localparam logic CFG_ARENA_SIZE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO       = 3'd1;
  localparam logic [ST_W-1:0] ST_TOO_BIG    = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd3;
  localparam logic [ST_W-1:0] ST_STACK_FULL = 3'd4;

  typedef enum logic [1:0] {
    CMD_REPLY,
    CMD_ALLOC,
    CMD_FREE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_MEM,
    SRC_BUMP
  } src_t;

  typedef enum logic {
    BK_IDLE,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]   status;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  user_addr;
    logic [CLS_W-1:0]   size_class;
    logic [BYTES_W-1:0] granted_bytes;
    logic [ST_W-1:0]    status;
  } res_t;

  function automatic logic [BYTES_W-1:0] class_size(input logic [CLS_W-1:0] cls);
    logic [BYTES_W-1:0] sz;
    case (cls)
      4'd0:    sz = 18'd16;
      4'd1:    sz = 18'd64;
      4'd2:    sz = 18'd128;
      4'd3:    sz = 18'd256;
      4'd4:    sz = 18'd512;
      4'd5:    sz = 18'd1024;
      4'd6:    sz = 18'd2048;
      4'd7:    sz = 18'd4096;
      4'd8:    sz = 18'd8192;
      4'd9:    sz = 18'd16384;
      4'd10:   sz = 18'd32768;
      4'd11:   sz = 18'd65536;
      4'd12:   sz = 18'd131072;
      default: sz = '0;
    endcase
    return sz;
  endfunction

endpackage

[design/scfa_front.sv]
// scfa_front: request classifier and command queue
// picks the size class and screens out error cases, depends on scfa_pkg
module scfa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_opcode,
  input  logic [31:0]                  in_req_size,
  input  logic [31:0]                  in_block_addr,
  input  logic [3:0]                   in_free_class,
  output logic                         cmd_valid,
  output scfa_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);
  import scfa_pkg::*;

  localparam int QP_W = $clog2(CQ_DEPTH);
  localparam int QC_W = $clog2(CQ_DEPTH + 1);

  cmd_t              cls_cmd;
  logic [ADDR_W:0]   total;
  logic [CLS_W-1:0]  alloc_cls;
  logic              push;

  cmd_t              q_r [CQ_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    total     = {1'b0, in_req_size} + (ADDR_W+1)'(HDR_BYTES);
    alloc_cls = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (total <= (ADDR_W+1)'(class_size(CLS_W'(k)))) begin
        alloc_cls = CLS_W'(k);
      end
    end
  end

  always_comb begin
    cls_cmd.kind   = CMD_REPLY;
    cls_cmd.cls    = in_free_class;
    cls_cmd.addr   = in_block_addr;
    cls_cmd.status = ST_OK;
    if (in_opcode == OP_FREE) begin
      if (in_block_addr != '0 && in_free_class < CLS_W'(NUM_CLASSES)) begin
        cls_cmd.kind = CMD_FREE;
      end
    end else if (in_req_size == '0) begin
      cls_cmd.status = ST_ZERO;
    end else if (total > (ADDR_W+1)'(MAX_BYTES)) begin
      cls_cmd.status = ST_TOO_BIG;
    end else begin
      cls_cmd.kind = CMD_ALLOC;
      cls_cmd.cls  = alloc_cls;
    end
  end

  // command queue
  assign in_full   = (cnt_r == QC_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule

[design/scfa_back.sv]
// scfa_back: command executor with class stacks, fill counts and bump pointer
// holds the arena registers and the stack memory, depends on scfa_pkg
module scfa_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         cmd_valid,
  input  scfa_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output scfa_pkg::res_t               res
);
  import scfa_pkg::*;

  bk_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   counts_r [NUM_CLASSES];
  logic [CNT_W-1:0]   counts_nxt [NUM_CLASSES];
  logic [ADDR_W-1:0]  bump_r, bump_nxt;
  logic [ADDR_W-1:0]  base_r, size_r;
  logic [ADDR_W-1:0]  blk_r, blk_nxt;
  src_t               src_r, src_nxt;
  logic [CLS_W-1:0]   pcls_r, pcls_nxt;
  logic [BYTES_W-1:0] pbytes_r, pbytes_nxt;
  logic [ST_W-1:0]    pstat_r, pstat_nxt;

  logic [ADDR_W-1:0]  mem [MEM_DEPTH];
  logic [ADDR_W-1:0]  mem_q_r;
  logic               mem_we, mem_re;
  logic [MEM_AW-1:0]  mem_addr;

  logic               take;
  logic [CNT_W-1:0]   cnt_sel, cnt_dec;
  logic [BYTES_W-1:0] size_sel;
  logic               fits;

  assign take     = (state_r == BK_IDLE) && cmd_valid && !res_full;
  assign cmd_pop  = take;
  assign cnt_sel  = counts_r[cmd.cls];
  assign cnt_dec  = cnt_sel - 1'b1;
  assign size_sel = class_size(cmd.cls);
  assign fits     = ({1'b0, bump_r} + (ADDR_W+1)'(size_sel)) <= {1'b0, size_r};

  always_comb begin
    counts_nxt = counts_r;
    bump_nxt   = bump_r;
    blk_nxt    = blk_r;
    src_nxt    = src_r;
    pcls_nxt   = pcls_r;
    pbytes_nxt = pbytes_r;
    pstat_nxt  = pstat_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = {cmd.cls, cnt_sel[PTR_W-1:0]};
    if (take) begin
      src_nxt    = SRC_NONE;
      pcls_nxt   = '0;
      pbytes_nxt = '0;
      pstat_nxt  = ST_OK;
      case (cmd.kind)
        CMD_FREE: begin
          if (cnt_sel >= CNT_W'(STACK_DEPTH)) begin
            pstat_nxt = ST_STACK_FULL;
          end else begin
            mem_we               = 1'b1;
            counts_nxt[cmd.cls]  = cnt_sel + 1'b1;
          end
        end
        CMD_ALLOC: begin
          if (cnt_sel != '0) begin
            mem_re              = 1'b1;
            mem_addr            = {cmd.cls, cnt_dec[PTR_W-1:0]};
            counts_nxt[cmd.cls] = cnt_dec;
            src_nxt             = SRC_MEM;
            pcls_nxt            = cmd.cls;
            pbytes_nxt          = size_sel;
          end else if (!fits) begin
            pstat_nxt = ST_NO_SPACE;
          end else begin
            blk_nxt    = base_r + bump_r;
            bump_nxt   = bump_r + ADDR_W'(size_sel);
            src_nxt    = SRC_BUMP;
            pcls_nxt   = cmd.cls;
            pbytes_nxt = size_sel;
          end
        end
        default: begin
          pstat_nxt = cmd.status;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (take) state_nxt = BK_DONE;
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    res_push          = (state_r == BK_DONE);
    res.size_class    = pcls_r;
    res.granted_bytes = pbytes_r;
    res.status        = pstat_r;
    case (src_r)
      SRC_MEM:  res.user_addr = mem_q_r;
      SRC_BUMP: res.user_addr = blk_r + ADDR_W'(HDR_BYTES);
      default:  res.user_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      bump_r  <= '0;
      base_r  <= '0;
      size_r  <= ADDR_W'(ARENA_RST);
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      bump_r   <= bump_nxt;
      counts_r <= counts_nxt;
      if (cfg_we && cfg_index == CFG_ARENA_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_ARENA_SIZE) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r    <= blk_nxt;
    src_r    <= src_nxt;
    pcls_r   <= pcls_nxt;
    pbytes_r <= pbytes_nxt;
    pstat_r  <= pstat_nxt;
  end

  // class stack memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd.addr;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

`ifndef SYNTHESIS
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> res_push) else $error("request taken without a result");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.kind != CMD_REPLY) |-> (cmd.cls < CLS_W'(NUM_CLASSES)))
    else $error("stack command with bad class");
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.kind != CMD_REPLY) |-> (cnt_sel <= CNT_W'(STACK_DEPTH)))
    else $error("stack count past depth");
`endif

endmodule

[design/scfa_resq.sv]
// scfa_resq: two entry result queue toward the caller
// parts the executor from the result side, depends on scfa_pkg
module scfa_resq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_push,
  input  scfa_pkg::res_t               res,
  output logic                         res_full,
  output logic                         out_empty,
  input  logic                         out_pop,
  output scfa_pkg::res_t               out_res
);
  import scfa_pkg::*;

  localparam int QP_W = $clog2(RQ_DEPTH);
  localparam int QC_W = $clog2(RQ_DEPTH + 1);

  res_t            q_r [RQ_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign res_full  = (cnt_r == QC_W'(RQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (res_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (res_push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!res_push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

[design/size_class_free_list_allocator.sv]
// size_class_free_list_allocator: top level, classifier, executor and result queue
// path: command queue, executor result registers, then result queue to the out ports
// a new request waits until the last result is pushed and the result queue has room
// reset: synchronous active low, clears counts, bump pointer, queues and arena base
// arena size resets to 1 MiB, stack contents are not cleared and need no sweep after reset
module size_class_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_opcode,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_block_addr,
  input  logic [3:0]  in_free_class,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_user_addr,
  output logic [3:0]  out_size_class,
  output logic [17:0] out_granted_bytes,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import scfa_pkg::*;

  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;
  logic  res_full, res_push;
  res_t  res, out_res;

  scfa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_req_size   (in_req_size),
    .in_block_addr (in_block_addr),
    .in_free_class (in_free_class),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  scfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  scfa_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_user_addr     = out_res.user_addr;
  assign out_size_class    = out_res.size_class;
  assign out_granted_bytes = out_res.granted_bytes;
  assign out_status        = out_res.status;

endmodule

[dv/size_class_free_list_allocator_tb.sv]
// testbench for size_class_free_list_allocator: directed table then random requests,
// replies checked in order against a local allocator predictor with its own stacks
// depends on scfa_pkg and the size_class_free_list_allocator design files
`timescale 1ns / 100ps

module size_class_free_list_allocator_tb;
  import scfa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 56;
  localparam int HELD_MAX    = 128;
  localparam int NUM_PHASES  = 5;

  typedef struct {
    logic [31:0] addr;
    logic [3:0]  cls;
  } held_block_t;

  typedef struct {
    logic        op;
    logic [31:0] req;
    logic [31:0] addr;
    logic [3:0]  cls;
    bit          typed;
    res_t        want;
  } request_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_opcode;
  logic [31:0] in_req_size;
  logic [31:0] in_block_addr;
  logic [3:0]  in_free_class;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_user_addr;
  logic [3:0]  out_size_class;
  logic [17:0] out_granted_bytes;
  logic [2:0]  out_status;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  // predictor state
  logic [31:0] free_stacks [NUM_CLASSES][STACK_DEPTH];
  int          stack_fill [NUM_CLASSES];
  logic [31:0] carved;
  logic [31:0] arena_base_sh;
  logic [31:0] arena_size_sh;

  res_t        awaited_replies [$];
  held_block_t held_blocks [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          stall_left;
  bit          tx_idle;
  bit          rx_idle;

  // arena written to base FFFFFFC0, size 131136 before these rows
  request_row_t opening_rows [22] = '{
    '{OP_ALLOC, 32'd0,         32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_ZERO}},
    '{OP_ALLOC, 32'hFFFF_FFFF, 32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_TOO_BIG}},
    '{OP_ALLOC, 32'd131041,    32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_TOO_BIG}},
    '{OP_ALLOC, 32'd131040,    32'd0,         4'd0,  1'b1,
      '{32'hFFFF_FFE0, 4'd12, 18'd131072, ST_OK}},
    '{OP_ALLOC, 32'd1,         32'd0,         4'd0,  1'b1,
      '{32'h0001_FFE0, 4'd1, 18'd64, ST_OK}},
    '{OP_ALLOC, 32'd32,        32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_NO_SPACE}},
    '{OP_ALLOC, 32'd33,        32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_NO_SPACE}},
    '{OP_FREE,  32'd0,         32'd0,         4'd1,  1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_FREE,  32'd0,         32'h1234_5678, 4'd13, 1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_FREE,  32'hFFFF_FFFF, 32'hDEAD_BEEF, 4'd15, 1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_FREE,  32'd0,         32'hFFFF_FFFF, 4'd12, 1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_FREE,  32'd0,         32'd1,         4'd12, 1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'd131040,    32'd0,         4'd0,  1'b0, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'd100000,    32'd0,         4'd0,  1'b0, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'd100000,    32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_NO_SPACE}},
    '{OP_FREE,  32'd0,         32'hAAAA_5555, 4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_FREE,  32'd0,         32'h5555_AAAA, 4'd4,  1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'd480,       32'd0,         4'd0,  1'b0, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'd481,       32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_NO_SPACE}},
    '{OP_FREE,  32'd0,         32'h0000_00FF, 4'd1,  1'b1, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'd32,        32'd0,         4'd0,  1'b0, '{32'd0, 4'd0, 18'd0, ST_OK}},
    '{OP_ALLOC, 32'hFFFF_FFE0, 32'd0,         4'd0,  1'b1, '{32'd0, 4'd0, 18'd0, ST_TOO_BIG}}
  };

  size_class_free_list_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_opcode         (in_opcode),
    .in_req_size       (in_req_size),
    .in_block_addr     (in_block_addr),
    .in_free_class     (in_free_class),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_user_addr     (out_user_addr),
    .out_size_class    (out_size_class),
    .out_granted_bytes (out_granted_bytes),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** size_class_free_list_allocator: FAILED **");
      $finish;
    end
  end

  // class 0 holds 16 bytes, class k above it holds 32 << k
  function automatic int unsigned span_of(input int k);
    return (k == 0) ? 32'd16 : (32'd32 << k);
  endfunction

  function automatic res_t resolve_request(input logic op, input logic [31:0] req,
                                           input logic [31:0] addr, input logic [3:0] cls);
    res_t        r;
    logic [32:0] total;
    int          k;
    r = '0;
    if (op == OP_FREE) begin
      if (addr == '0 || cls >= NUM_CLASSES) return r;
      if (stack_fill[cls] >= STACK_DEPTH) begin
        r.status = ST_STACK_FULL;
        return r;
      end
      free_stacks[cls][stack_fill[cls]] = addr;
      stack_fill[cls]++;
      return r;
    end
    if (req == '0) begin
      r.status = ST_ZERO;
      return r;
    end
    total = {1'b0, req} + 33'(HDR_BYTES);
    k = 0;
    while (k < NUM_CLASSES && total > 33'(span_of(k))) k++;
    if (k == NUM_CLASSES) begin
      r.status = ST_TOO_BIG;
      return r;
    end
    if (stack_fill[k] > 0) begin
      stack_fill[k]--;
      r.user_addr     = free_stacks[k][stack_fill[k]];
      r.size_class    = 4'(k);
      r.granted_bytes = 18'(span_of(k));
      return r;
    end
    if ({1'b0, carved} + 33'(span_of(k)) > {1'b0, arena_size_sh}) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    r.user_addr     = arena_base_sh + carved + 32'(HDR_BYTES);
    r.size_class    = 4'(k);
    r.granted_bytes = 18'(span_of(k));
    carved          = carved + span_of(k);
    return r;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_ARENA_BASE) arena_base_sh = data;
    else arena_size_sh = data;
  endtask

  task automatic send_request(input logic op, input logic [31:0] req, input logic [31:0] addr,
                              input logic [3:0] cls, input bit typed, input res_t want);
    res_t        got;
    held_block_t blk;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_opcode     <= op;
    in_req_size   <= req;
    in_block_addr <= addr;
    in_free_class <= cls;
    do @(posedge clk); while (in_full);
    got = resolve_request(op, req, addr, cls);
    awaited_replies.push_back(typed ? want : got);
    if (op == OP_ALLOC && got.status == ST_OK && held_blocks.size() < HELD_MAX) begin
      blk.addr = got.user_addr;
      blk.cls  = got.size_class;
      held_blocks.push_back(blk);
    end
  endtask

  task automatic drain_replies;
    in_push <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // fills one class stack to the top, then overflows it
  task automatic flood_stack(input int c);
    while (stack_fill[c] < STACK_DEPTH)
      send_request(OP_FREE, $urandom(), $urandom() | 32'h1, 4'(c), 1'b0, '0);
    repeat (3) send_request(OP_FREE, '0, $urandom() | 32'h1, 4'(c), 1'b0, '0);
  endtask

  task automatic send_random(output bit counted);
    int          r;
    int          k;
    int          pick;
    int unsigned lo;
    int unsigned hi;
    logic        op;
    logic [31:0] req;
    logic [31:0] addr;
    logic [3:0]  cls;
    held_block_t blk;
    r    = $urandom_range(0, 99);
    op   = OP_ALLOC;
    req  = $urandom();
    addr = $urandom();
    cls  = 4'($urandom_range(0, 15));
    if (r >= 50 && r < 85 && held_blocks.size() != 0) begin
      // well-formed free of a block handed out earlier
      pick = $urandom_range(0, held_blocks.size() - 1);
      blk  = held_blocks[pick];
      held_blocks.delete(pick);
      op   = OP_FREE;
      addr = blk.addr;
      cls  = blk.cls;
    end else if (r >= 85 && r < 90) begin
      op = OP_FREE;
      if ($urandom_range(0, 3) == 0) addr = '0;
    end else if (r >= 90 && r < 95) begin
      case ($urandom_range(0, 3))
        0:       req = '0;
        1:       req = $urandom();
        2:       req = 32'hFFFF_FFFF - $urandom_range(0, 63);
        default: req = 32'(MAX_BYTES - HDR_BYTES - 1) + $urandom_range(0, 2);
      endcase
    end else if (r >= 95 && held_blocks.size() != 0) begin
      // double free, possibly onto the wrong class
      op   = OP_FREE;
      addr = held_blocks[$urandom_range(0, held_blocks.size() - 1)].addr;
      cls  = 4'($urandom_range(0, NUM_CLASSES - 1));
    end else begin
      k  = $urandom_range(1, NUM_CLASSES - 1);
      lo = (k == 1) ? 32'd1 : span_of(k - 1) - 31;
      hi = span_of(k) - 32'(HDR_BYTES);
      case ($urandom_range(0, 5))
        0:       req = lo;
        1:       req = hi;
        default: req = $urandom_range(hi, lo);
      endcase
    end
    counted = !(op == OP_FREE && (addr == '0 || cls >= NUM_CLASSES));
    send_request(op, req, addr, cls, 1'b0, '0);
  endtask

  // reply side: checks each popped reply, stalls in short bursts
  initial begin
    res_t want;
    out_pop   <= 1'b0;
    stall_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_pop && !out_empty) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: addr %h class %0d bytes %0d status %0d",
                     out_user_addr, out_size_class, out_granted_bytes, out_status);
        end else begin
          want = awaited_replies.pop_front();
          if (out_user_addr !== want.user_addr || out_size_class !== want.size_class ||
              out_granted_bytes !== want.granted_bytes || out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                       want.user_addr, want.size_class, want.granted_bytes, want.status,
                       out_user_addr, out_size_class, out_granted_bytes, out_status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    int          phase;
    int          served;
    bit          counted;
    logic [31:0] base_v;
    logic [31:0] size_v;
    rst_n         <= 1'b0;
    in_push       <= 1'b0;
    in_opcode     <= OP_ALLOC;
    in_req_size   <= '0;
    in_block_addr <= '0;
    in_free_class <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ARENA_BASE;
    cfg_wdata     <= '0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    foreach (stack_fill[i]) stack_fill[i] = 0;
    carved        = '0;
    arena_base_sh = '0;
    arena_size_sh = 32'(ARENA_RST);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // near-wrap base, room for exactly one 128K block and one 64 byte block
    write_reg(CFG_ARENA_BASE, 32'hFFFF_FFC0);
    write_reg(CFG_ARENA_SIZE, 32'd131136);
    foreach (opening_rows[i])
      send_request(opening_rows[i].op, opening_rows[i].req, opening_rows[i].addr,
                   opening_rows[i].cls, opening_rows[i].typed, opening_rows[i].want);
    drain_replies();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          base_v = 32'h1000_0000;
          size_v = 32'h0008_0000;
        end
        1: begin
          base_v = '0;
          size_v = '0;
        end
        2: begin
          base_v = 32'hFFFF_FFFF;
          size_v = 32'hFFFF_FFFF;
        end
        3: begin
          base_v = $urandom();
          size_v = carved + $urandom_range(0, 32'h0020_0000);
        end
        default: begin
          base_v  = $urandom();
          size_v  = 32'hFFFF_FFFF;
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
      endcase
      write_reg(CFG_ARENA_BASE, base_v);
      write_reg(CFG_ARENA_SIZE, size_v);
      if (phase == 1) flood_stack(0);
      if (phase == 3) flood_stack($urandom_range(1, NUM_CLASSES - 1));
      served = 0;
      while (served < PHASE_ITEMS) begin
        send_random(counted);
        if (counted) served++;
      end
      drain_replies();
    end

    if (mismatches == 0) begin
      $display("** size_class_free_list_allocator: PASSED **");
    end else begin
      $display("** size_class_free_list_allocator: FAILED **");
    end
    $finish;
  end

endmodule
